@@ hdl/lifs_pkg.sv @@
// Shared types, codes and constants for the LED indicator flag sequencer.
package lifs_pkg;

    localparam int CMD_W      = 3;
    localparam int LED_IDX_W  = 4;
    localparam int COLOR_W    = 24;
    localparam int FLAG_W     = 8;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_SET_COLOR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REPLACE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POST      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONCE_MASK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LATER_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_COLOR  = 3'd3;

    // configuration reset values
    localparam logic [FLAG_W-1:0]  RST_BLINK_MASK = 8'h01;
    localparam logic [FLAG_W-1:0]  RST_ONCE_MASK  = 8'h02;
    localparam logic [FLAG_W-1:0]  RST_LATER_MASK = 8'h04;
    localparam logic [COLOR_W-1:0] RST_OFF_COLOR  = 24'h000000;

    typedef enum logic [2:0] {
        OP_SET_COLOR,
        OP_REPLACE,
        OP_CLEAR,
        OP_READ,
        OP_POST,
        OP_BAD_INDEX
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [LED_IDX_W-1:0] led_index;
        logic [COLOR_W-1:0]   color;
        logic [FLAG_W-1:0]    flags;
    } t_item;

    typedef struct packed {
        logic  push;
        t_item item;
    } t_q_wr;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_rd;

    typedef struct packed {
        logic [FLAG_W-1:0]  blink_mask;
        logic [FLAG_W-1:0]  once_mask;
        logic [FLAG_W-1:0]  later_mask;
        logic [COLOR_W-1:0] off_color;
    } t_cfg;

endpackage

@@ hdl/lifs_if.sv @@
// Channel interfaces: command input, result output and configuration write.
interface lifs_in_if;
    logic                           valid;
    logic                           ready;
    logic [lifs_pkg::CMD_W-1:0]     command;
    logic [lifs_pkg::LED_IDX_W-1:0] led_index;
    logic [lifs_pkg::COLOR_W-1:0]   color;
    logic [lifs_pkg::FLAG_W-1:0]    flags;

    modport source (output valid, command, led_index, color, flags, input ready);
    modport sink   (input valid, command, led_index, color, flags, output ready);
endinterface

interface lifs_out_if;
    logic                           valid;
    logic                           ready;
    logic [lifs_pkg::LED_IDX_W-1:0] out_index;
    logic [lifs_pkg::CHAN_W-1:0]    red;
    logic [lifs_pkg::CHAN_W-1:0]    green;
    logic [lifs_pkg::CHAN_W-1:0]    blue;
    logic [lifs_pkg::FLAG_W-1:0]    flag_byte;
    logic                           index_error;
    logic                           last;

    modport source (output valid, out_index, red, green, blue, flag_byte, index_error, last,
                    input ready);
    modport sink   (input valid, out_index, red, green, blue, flag_byte, index_error, last,
                    output ready);
endinterface

interface lifs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lifs_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [lifs_pkg::CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

@@ hdl/lifs_front.sv @@
// Front end: accepts commands, drops unknown codes, tags bad indexes.
module lifs_front #(
    parameter int NUM_LEDS = 7
) (
    lifs_in_if.sink          i_in,
    input  logic             i_q_full,
    output lifs_pkg::t_q_wr  o_q_wr
);
    import lifs_pkg::*;

    logic accept;
    logic drop;
    t_op  op;
    logic bad_index;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        drop = 1'b0;
        case (i_in.command)
            CMD_SET_COLOR: op = OP_SET_COLOR;
            CMD_REPLACE:   op = OP_REPLACE;
            CMD_CLEAR:     op = OP_CLEAR;
            CMD_POST:      op = OP_POST;
            CMD_READ:      op = OP_READ;
            default: begin
                op   = OP_READ;
                drop = 1'b1;
            end
        endcase
    end

    // post ignores the index; everything else is checked against the LED count
    assign bad_index = (op != OP_POST) && (i_in.led_index >= LED_IDX_W'(NUM_LEDS));

    always_comb begin
        o_q_wr.push           = accept && !drop;
        o_q_wr.item.op        = bad_index ? OP_BAD_INDEX : op;
        o_q_wr.item.led_index = i_in.led_index;
        o_q_wr.item.color     = i_in.color;
        o_q_wr.item.flags     = i_in.flags;
    end

endmodule

@@ hdl/lifs_queue.sv @@
// Short command queue between the front end and the back end.
module lifs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lifs_pkg::t_q_wr  i_q_wr,
    input  logic             i_pop,
    output logic             o_full,
    output lifs_pkg::t_q_rd  o_q_rd
);
    import lifs_pkg::*;

    t_item              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic               do_push;
    logic               do_pop;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_q_rd.valid = (r_count != '0);
    assign o_q_rd.item  = r_entry[r_rd_ptr];

    assign do_push = i_q_wr.push && !o_full;
    assign do_pop  = i_pop && o_q_rd.valid;

    assign n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_q_wr.item;
        end
    end

endmodule

@@ hdl/lifs_back.sv @@
// Back end: indicator state, configuration registers and result sequencing.
module lifs_back #(
    parameter int NUM_LEDS = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lifs_pkg::t_q_rd  i_q_rd,
    output logic             o_pop,
    lifs_cfg_if.sink         i_cfg,
    lifs_out_if.source       o_out
);
    import lifs_pkg::*;

    localparam int IW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_cfg   r_cfg;

    logic [COLOR_W-1:0] r_steady  [NUM_LEDS];
    logic [COLOR_W-1:0] r_pending [NUM_LEDS];
    logic [FLAG_W-1:0]  r_flag    [NUM_LEDS];
    logic [COLOR_W-1:0] r_shown   [NUM_LEDS];

    t_item              r_item;
    logic [IW-1:0]      r_walk;

    logic                 r_out_valid;
    logic [LED_IDX_W-1:0] r_out_index;
    logic [COLOR_W-1:0]   r_out_color;
    logic [FLAG_W-1:0]    r_out_flags;
    logic                 r_out_error;
    logic                 r_out_last;

    logic               can_emit;
    logic               is_post;
    logic               walk_last;
    logic [IW-1:0]      sel;
    logic [FLAG_W-1:0]  f_cur;
    logic [COLOR_W-1:0] steady_cur;
    logic [COLOR_W-1:0] pending_cur;
    logic [COLOR_W-1:0] shown_cur;
    logic               blink_on;
    logic               once_on;
    logic               later_on;
    logic [COLOR_W-1:0] post_cand;
    logic [FLAG_W-1:0]  post_flags;
    logic               post_commit;
    logic [FLAG_W-1:0]  cmd_flags;
    logic               set_pending;

    assign i_cfg.ready = 1'b1;

    assign can_emit  = !r_out_valid || o_out.ready;
    assign is_post   = (r_item.op == OP_POST);
    assign walk_last = (r_walk == IW'(NUM_LEDS - 1));
    assign o_pop     = (r_state == S_IDLE) && i_q_rd.valid;

    assign sel         = is_post ? r_walk : r_item.led_index[IW-1:0];
    assign f_cur       = r_flag[sel];
    assign steady_cur  = r_steady[sel];
    assign pending_cur = r_pending[sel];
    assign shown_cur   = r_shown[sel];

    assign blink_on = (f_cur & r_cfg.blink_mask) != '0;
    assign once_on  = (f_cur & r_cfg.once_mask) != '0;
    assign later_on = (f_cur & r_cfg.later_mask) != '0;

    // per-indicator post decision
    always_comb begin
        post_cand   = steady_cur;
        post_flags  = f_cur;
        post_commit = 1'b0;
        if (blink_on && (shown_cur != r_cfg.off_color)) begin
            post_cand = r_cfg.off_color;
        end
        if (later_on) begin
            post_commit = !once_on;
            post_flags  = f_cur & ~r_cfg.later_mask;
        end else if (once_on) begin
            post_cand  = pending_cur;
            post_flags = f_cur & ~r_cfg.once_mask;
        end
    end

    assign set_pending = (r_item.flags & (r_cfg.once_mask | r_cfg.later_mask)) != '0;

    always_comb begin
        case (r_item.op)
            OP_SET_COLOR: cmd_flags = r_item.flags;
            OP_REPLACE:   cmd_flags = r_item.flags;
            OP_CLEAR:     cmd_flags = f_cur & ~r_item.flags;
            default:      cmd_flags = f_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_out_valid       <= 1'b0;
            r_walk            <= '0;
            r_cfg.blink_mask  <= RST_BLINK_MASK;
            r_cfg.once_mask   <= RST_ONCE_MASK;
            r_cfg.later_mask  <= RST_LATER_MASK;
            r_cfg.off_color   <= RST_OFF_COLOR;
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_steady[i]  <= '0;
                r_pending[i] <= '0;
                r_flag[i]    <= '0;
                r_shown[i]   <= '0;
            end
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.reg_index)
                    CFG_BLINK_MASK: r_cfg.blink_mask <= i_cfg.wr_data[FLAG_W-1:0];
                    CFG_ONCE_MASK:  r_cfg.once_mask  <= i_cfg.wr_data[FLAG_W-1:0];
                    CFG_LATER_MASK: r_cfg.later_mask <= i_cfg.wr_data[FLAG_W-1:0];
                    CFG_OFF_COLOR:  r_cfg.off_color  <= i_cfg.wr_data[COLOR_W-1:0];
                    default: begin
                    end
                endcase
            end

            if ((r_state == S_EXEC) && can_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_q_rd.valid) begin
                        r_walk  <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (can_emit) begin
                        case (r_item.op)
                            OP_POST: begin
                                r_flag[sel]  <= post_flags;
                                r_shown[sel] <= post_cand;
                                if (post_commit) begin
                                    r_steady[sel] <= pending_cur;
                                end
                                if (walk_last) begin
                                    r_walk  <= '0;
                                    r_state <= S_IDLE;
                                end else begin
                                    r_walk <= r_walk + 1'b1;
                                end
                            end
                            OP_BAD_INDEX: begin
                                r_state <= S_IDLE;
                            end
                            default: begin
                                if (r_item.op == OP_SET_COLOR) begin
                                    if (set_pending) begin
                                        r_pending[sel] <= r_item.color;
                                    end else begin
                                        r_steady[sel] <= r_item.color;
                                    end
                                end
                                r_flag[sel] <= cmd_flags;
                                r_state     <= S_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // command and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q_rd.item;
        end
        if ((r_state == S_EXEC) && can_emit) begin
            case (r_item.op)
                OP_POST: begin
                    r_out_index <= LED_IDX_W'(r_walk);
                    r_out_color <= post_cand;
                    r_out_flags <= post_flags;
                    r_out_error <= 1'b0;
                    r_out_last  <= walk_last;
                end
                OP_BAD_INDEX: begin
                    r_out_index <= r_item.led_index;
                    r_out_color <= '0;
                    r_out_flags <= '0;
                    r_out_error <= 1'b1;
                    r_out_last  <= 1'b1;
                end
                default: begin
                    r_out_index <= r_item.led_index;
                    r_out_color <= shown_cur;
                    r_out_flags <= cmd_flags;
                    r_out_error <= 1'b0;
                    r_out_last  <= 1'b1;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_index   = r_out_index;
    assign o_out.red         = r_out_color[CHAN_W-1:0];
    assign o_out.green       = r_out_color[2*CHAN_W-1:CHAN_W];
    assign o_out.blue        = r_out_color[3*CHAN_W-1:2*CHAN_W];
    assign o_out.flag_byte   = r_out_flags;
    assign o_out.index_error = r_out_error;
    assign o_out.last        = r_out_last;

endmodule

@@ hdl/led_indicator_flag_sequencer.sv @@
// Top level of the LED indicator flag sequencer.
// Usage:
//   i_in  : command channel (command, led_index, color, flags), valid/ready.
//   o_out : result channel (out_index, red, green, blue, flag_byte, index_error, last).
//   i_cfg : register writes (reg_index, wr_data); always ready, apply while idle.
// Set color, replace, clear and read flags give one result; post gives NUM_LEDS
// results in index order with last on the final one. Unknown commands give none.
// A command index at or above NUM_LEDS gives one result with index_error set.
// A command is written into the queue, popped into the back end's command
// register, and each result is then registered. A post walks one indicator per
// cycle through the single state read port, pausing while the result register stalls.
// A two-entry queue lets new commands be taken while the back end works.
// When o_out.ready is low the result register holds and the walk pauses; the
// queue then fills and i_in.ready drops.
// Reset clears all colors and flags to zero and loads the default flag masks.
module led_indicator_flag_sequencer #(
    parameter int NUM_LEDS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lifs_in_if.sink     i_in,
    lifs_cfg_if.sink    i_cfg,
    lifs_out_if.source  o_out
);
    import lifs_pkg::*;

    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_full;
    logic  q_pop;

    lifs_front #(
        .NUM_LEDS (NUM_LEDS)
    ) u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_wr   (q_wr)
    );

    lifs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_wr  (q_wr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_q_rd  (q_rd)
    );

    lifs_back #(
        .NUM_LEDS (NUM_LEDS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_rd  (q_rd),
        .o_pop   (q_pop),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the LED indicator flag sequencer: directed table, then random.
`timescale 1ns / 1ps

module testbench;
    import lifs_pkg::*;

    localparam int NUM_LEDS        = 7;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 4 * (NUM_LEDS + 2);
    localparam int PHASE_ITEMS     = 30;
    localparam int NUM_PHASES      = 5;
    localparam int NUM_STEPS       = 23;

    // command codes the block takes but ignores
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LAST  = 3'd7;

    typedef struct packed {
        logic [LED_IDX_W-1:0] out_index;
        logic [CHAN_W-1:0]    red;
        logic [CHAN_W-1:0]    green;
        logic [CHAN_W-1:0]    blue;
        logic [FLAG_W-1:0]    flag_byte;
        logic                 index_error;
        logic                 last;
    } t_led_result;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [LED_IDX_W-1:0] led_index;
        logic [COLOR_W-1:0]   color;
        logic [FLAG_W-1:0]    flags;
        logic                 fixed;
        t_led_result          want;
    } t_step_row;

    logic i_clk;
    logic i_rst_n;

    lifs_in_if  cmd_ch ();
    lifs_cfg_if cfg_ch ();
    lifs_out_if res_ch ();

    led_indicator_flag_sequencer #(
        .NUM_LEDS (NUM_LEDS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_out   (res_ch)
    );

    // shadow state of the indicators
    logic [COLOR_W-1:0] led_steady  [NUM_LEDS];
    logic [COLOR_W-1:0] led_pending [NUM_LEDS];
    logic [FLAG_W-1:0]  led_flags   [NUM_LEDS];
    logic [COLOR_W-1:0] led_shown   [NUM_LEDS];
    logic [FLAG_W-1:0]  cfg_blink;
    logic [FLAG_W-1:0]  cfg_once;
    logic [FLAG_W-1:0]  cfg_later;
    logic [COLOR_W-1:0] cfg_off;

    t_led_result due_results[$];
    t_led_result oldest_due;
    t_step_row   directed_steps [NUM_STEPS];

    int error_count    = 0;
    int commands_sent  = 0;
    int posts_sent     = 0;
    int results_seen   = 0;
    int settings_used  = 1;
    int idle_cycles    = 0;
    bit no_idle        = 1'b0;
    bit hold_off_req   = 1'b0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic t_led_result make_result(input logic [LED_IDX_W-1:0] idx,
                                                input logic [COLOR_W-1:0] col,
                                                input logic [FLAG_W-1:0] fl,
                                                input logic err,
                                                input logic last);
        t_led_result r;
        r.out_index   = idx;
        r.red         = col[7:0];
        r.green       = col[15:8];
        r.blue        = col[23:16];
        r.flag_byte   = fl;
        r.index_error = err;
        r.last        = last;
        return r;
    endfunction

    function automatic void reset_shadow();
        cfg_blink = RST_BLINK_MASK;
        cfg_once  = RST_ONCE_MASK;
        cfg_later = RST_LATER_MASK;
        cfg_off   = RST_OFF_COLOR;
        for (int n = 0; n < NUM_LEDS; n++) begin
            led_steady[n]  = '0;
            led_pending[n] = '0;
            led_flags[n]   = '0;
            led_shown[n]   = '0;
        end
    endfunction

    // appends one expected result at the tail
    function automatic void add_due(input t_led_result r);
        due_results.insert(due_results.size(), r);
    endfunction

    // updates the shadow state and queues the results one command produces
    function automatic void predict_command(input logic [CMD_W-1:0] cmd,
                                            input logic [LED_IDX_W-1:0] idx,
                                            input logic [COLOR_W-1:0] col,
                                            input logic [FLAG_W-1:0] fl);
        logic [FLAG_W-1:0]  f;
        logic [COLOR_W-1:0] cand;
        if (cmd == CMD_POST) begin
            for (int n = 0; n < NUM_LEDS; n++) begin
                f    = led_flags[n];
                cand = led_steady[n];
                if ((f & cfg_blink) != '0 && led_shown[n] != cfg_off)
                    cand = cfg_off;
                if ((f & cfg_later) != '0) begin
                    if ((f & cfg_once) == '0)
                        led_steady[n] = led_pending[n];
                    f = f & ~cfg_later;
                end else if ((f & cfg_once) != '0) begin
                    cand = led_pending[n];
                    f    = f & ~cfg_once;
                end
                led_flags[n] = f;
                led_shown[n] = cand;
                add_due(make_result(LED_IDX_W'(n), cand, f, 1'b0, n == NUM_LEDS - 1));
            end
        end else if (cmd > CMD_READ) begin
            // ignored, nothing comes back
        end else if (idx >= NUM_LEDS) begin
            add_due(make_result(idx, '0, '0, 1'b1, 1'b1));
        end else begin
            case (cmd)
                CMD_SET_COLOR: begin
                    if ((fl & (cfg_once | cfg_later)) != '0)
                        led_pending[idx] = col;
                    else
                        led_steady[idx] = col;
                    led_flags[idx] = fl;
                end
                CMD_REPLACE: led_flags[idx] = fl;
                CMD_CLEAR:   led_flags[idx] = led_flags[idx] & ~fl;
                default: ;
            endcase
            add_due(make_result(idx, led_shown[idx], led_flags[idx], 1'b0, 1'b1));
        end
    endfunction

    task automatic report_error(input string msg);
        if (error_count < 100)
            $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                   results_seen, name, got, want));
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd,
                            input logic [LED_IDX_W-1:0] idx,
                            input logic [COLOR_W-1:0] col,
                            input logic [FLAG_W-1:0] fl,
                            input logic use_fixed,
                            input t_led_result fixed);
        int gap;
        int first_new;
        gap = 0;
        if (!no_idle && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.valid     = 1'b1;
        cmd_ch.command   = cmd;
        cmd_ch.led_index = idx;
        cmd_ch.color     = col;
        cmd_ch.flags     = fl;
        do @(posedge i_clk); while (!cmd_ch.ready);
        first_new = due_results.size();
        predict_command(cmd, idx, col, fl);
        if (use_fixed)
            due_results[first_new] = fixed;
        commands_sent++;
        if (cmd == CMD_POST)
            posts_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid     = 1'b1;
        cfg_ch.reg_index = idx;
        cfg_ch.wr_data   = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_BLINK_MASK: cfg_blink = data[FLAG_W-1:0];
            CFG_ONCE_MASK:  cfg_once  = data[FLAG_W-1:0];
            CFG_LATER_MASK: cfg_later = data[FLAG_W-1:0];
            CFG_OFF_COLOR:  cfg_off   = data[COLOR_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_config(input logic [FLAG_W-1:0] blink, input logic [FLAG_W-1:0] once,
                              input logic [FLAG_W-1:0] later, input logic [COLOR_W-1:0] off);
        write_reg(CFG_BLINK_MASK, CFG_DATA_W'(blink));
        write_reg(CFG_ONCE_MASK, CFG_DATA_W'(once));
        write_reg(CFG_LATER_MASK, CFG_DATA_W'(later));
        write_reg(CFG_OFF_COLOR, CFG_DATA_W'(off));
        settings_used++;
    endtask

    // drop valid, let every result come back, then let ignored commands drain
    task automatic wait_idle();
        @(negedge i_clk);
        cmd_ch.valid = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [FLAG_W-1:0] random_flags();
        logic [FLAG_W-1:0] fl;
        if ($urandom_range(0, 2) == 0) begin
            fl = FLAG_W'($urandom_range(0, 255));
        end else begin
            fl = '0;
            if ($urandom_range(0, 1) == 1) fl = fl | cfg_blink;
            if ($urandom_range(0, 1) == 1) fl = fl | cfg_once;
            if ($urandom_range(0, 1) == 1) fl = fl | cfg_later;
            if ($urandom_range(0, 5) == 0) fl = fl | FLAG_W'($urandom_range(0, 255));
        end
        return fl;
    endfunction

    task automatic run_random(input int target, input bit with_hold);
        logic [CMD_W-1:0]     addressed_cmds [4];
        logic [CMD_W-1:0]     cmd;
        logic [LED_IDX_W-1:0] idx;
        logic [COLOR_W-1:0]   col;
        logic [FLAG_W-1:0]    fl;
        int counted;
        int pick;
        addressed_cmds = '{CMD_SET_COLOR, CMD_REPLACE, CMD_CLEAR, CMD_READ};
        counted = 0;
        while (counted < target) begin
            if (with_hold && counted == 5)
                hold_off_req = 1'b1;
            pick = $urandom_range(0, 99);
            idx  = LED_IDX_W'($urandom_range(0, NUM_LEDS - 1));
            fl   = random_flags();
            col  = ($urandom_range(0, 7) == 0) ? cfg_off : COLOR_W'($urandom);
            if (pick < 30) begin
                cmd = CMD_POST;
                idx = LED_IDX_W'($urandom_range(0, 15));
            end else if (pick < 55) begin
                cmd = CMD_SET_COLOR;
            end else if (pick < 67) begin
                cmd = CMD_REPLACE;
            end else if (pick < 77) begin
                cmd = CMD_CLEAR;
            end else if (pick < 87) begin
                cmd = CMD_READ;
            end else if (pick < 95) begin
                cmd = addressed_cmds[$urandom_range(0, 3)];
                idx = LED_IDX_W'($urandom_range(NUM_LEDS, 15));
            end else begin
                cmd = CMD_W'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
                idx = LED_IDX_W'($urandom_range(0, 15));
            end
            send_cmd(cmd, idx, col, fl, 1'b0, '0);
            if (cmd <= CMD_READ)
                counted++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (due_results.size() == 0) begin
                report_error($sformatf("unexpected result for indicator %0d",
                                       res_ch.out_index));
            end else begin
                oldest_due = due_results.pop_front();
                check_field("out_index", res_ch.out_index, oldest_due.out_index);
                check_field("red", res_ch.red, oldest_due.red);
                check_field("green", res_ch.green, oldest_due.green);
                check_field("blue", res_ch.blue, oldest_due.blue);
                check_field("flag_byte", res_ch.flag_byte, oldest_due.flag_byte);
                check_field("index_error", res_ch.index_error, oldest_due.index_error);
                check_field("last", res_ch.last, oldest_due.last);
            end
        end
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: %0d cycles without a transaction, %0d results outstanding",
                         idle_cycles, due_results.size());
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // result receiver: random stalls, one long hold-off on request
    initial begin
        res_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                res_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                res_ch.ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end else begin
                res_ch.ready = 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = CMD_READ;
        cmd_ch.led_index = '0;
        cmd_ch.color     = '0;
        cmd_ch.flags     = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = CFG_BLINK_MASK;
        cfg_ch.wr_data   = '0;
        reset_shadow();

        // fixed expectations hold for the reset masks and an all-off state
        directed_steps = '{
            '{CMD_READ, 4'd0, 24'h000000, 8'h00, 1'b1, make_result(4'd0, '0, 8'h00, 1'b0, 1'b1)},
            '{CMD_READ, 4'd6, 24'h000000, 8'h00, 1'b1, make_result(4'd6, '0, 8'h00, 1'b0, 1'b1)},
            '{CMD_READ, 4'd7, 24'h000000, 8'h00, 1'b1, make_result(4'd7, '0, 8'h00, 1'b1, 1'b1)},
            '{CMD_SET_COLOR, 4'd15, 24'hFFFFFF, 8'hFF, 1'b1,
              make_result(4'd15, '0, 8'h00, 1'b1, 1'b1)},
            '{CMD_SET_COLOR, 4'd0, 24'hFFFFFF, 8'h00, 1'b1,
              make_result(4'd0, '0, 8'h00, 1'b0, 1'b1)},
            '{CMD_SET_COLOR, 4'd1, 24'h0000FF, 8'h02, 1'b1,
              make_result(4'd1, '0, 8'h02, 1'b0, 1'b1)},
            '{CMD_SET_COLOR, 4'd2, 24'h00FF00, 8'h04, 1'b1,
              make_result(4'd2, '0, 8'h04, 1'b0, 1'b1)},
            '{CMD_SET_COLOR, 4'd3, 24'hFF0000, 8'h01, 1'b1,
              make_result(4'd3, '0, 8'h01, 1'b0, 1'b1)},
            '{CMD_SET_COLOR, 4'd4, 24'h123456, 8'h06, 1'b1,
              make_result(4'd4, '0, 8'h06, 1'b0, 1'b1)},
            '{CMD_SET_COLOR, 4'd5, 24'hABCDEF, 8'hFF, 1'b1,
              make_result(4'd5, '0, 8'hFF, 1'b0, 1'b1)},
            '{CMD_REPLACE, 4'd6, 24'hFFFFFF, 8'hFF, 1'b1,
              make_result(4'd6, '0, 8'hFF, 1'b0, 1'b1)},
            '{CMD_CLEAR, 4'd6, 24'h000000, 8'h0F, 1'b1,
              make_result(4'd6, '0, 8'hF0, 1'b0, 1'b1)},
            '{CMD_UNKNOWN_FIRST, 4'd0, 24'h000000, 8'h00, 1'b0, '0},
            '{CMD_UNKNOWN_LAST, 4'd15, 24'hFFFFFF, 8'hFF, 1'b0, '0},
            '{CMD_POST, 4'd15, 24'hFFFFFF, 8'hFF, 1'b0, '0},
            '{CMD_POST, 4'd0, 24'h000000, 8'h00, 1'b0, '0},
            '{CMD_POST, 4'd3, 24'h5A5A5A, 8'hA5, 1'b0, '0},
            '{CMD_REPLACE, 4'd0, 24'h000000, 8'h00, 1'b0, '0},
            '{CMD_CLEAR, 4'd5, 24'h000000, 8'hFF, 1'b0, '0},
            '{CMD_READ, 4'd5, 24'h000000, 8'h00, 1'b0, '0},
            '{CMD_UNKNOWN_MID, 4'd2, 24'h000000, 8'h00, 1'b0, '0},
            '{CMD_POST, 4'd0, 24'h000000, 8'h00, 1'b0, '0},
            '{CMD_READ, 4'd15, 24'h000000, 8'h00, 1'b1,
              make_result(4'd15, '0, 8'h00, 1'b1, 1'b1)}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        for (int s = 0; s < NUM_STEPS; s++)
            send_cmd(directed_steps[s].cmd, directed_steps[s].led_index,
                     directed_steps[s].color, directed_steps[s].flags,
                     directed_steps[s].fixed, directed_steps[s].want);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: set_config(8'h00, 8'h00, 8'h00, 24'h000000);
                1: set_config(8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF);
                2: set_config(8'h03, 8'h06, 8'h0C, 24'h123456);
                3: set_config(FLAG_W'($urandom_range(0, 255)), FLAG_W'($urandom_range(0, 255)),
                              FLAG_W'($urandom_range(0, 255)), COLOR_W'($urandom));
                default: set_config(8'h01, 8'h02, 8'h04, 24'h000000);
            endcase
            // last phase runs at full rate on both sides
            if (p == NUM_PHASES - 1)
                no_idle = 1'b1;
            run_random(PHASE_ITEMS, p == 2);
        end
        wait_idle();

        $display("covered %0d commands (%0d posts), %0d results checked, %0d mask settings",
                 commands_sent, posts_sent, results_seen, settings_used);
        $display("%0d mismatches", error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
